@@ rtl/fpba_pkg.sv @@
// fpba_pkg: request and result types, fit policy codes, register indexes
// and sequencer states of the fit-policy block allocator
// no dependencies
package fpba_pkg;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_NEXT  = 2'd1,
		POL_BEST  = 2'd2,
		POL_WORST = 2'd3
	} policy_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	typedef enum logic {
		REG_FIT_POLICY    = 1'b0,
		REG_BLOCKS_IN_USE = 1'b1
	} reg_idx_t;

	localparam int unsigned CFG_DATA_W = 4;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam logic [3:0]  BIU_RESET  = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_DONE = 2'd2
	} state_t;

	typedef struct packed {
		logic        opcode;
		logic [2:0]  block_index;
		logic [15:0] size;
	} req_t;

	typedef struct packed {
		logic        granted;
		logic [2:0]  chosen_block;
		logic [15:0] left_over;
	} res_t;

	// control from the sequencer to the candidate selector
	typedef struct packed {
		logic    clear;
		logic    vld;
		policy_t policy;
	} sel_ctl_t;

endpackage

@@ rtl/fpba_ram.sv @@
// fpba_ram: generic single-write, single-read synchronous ram
// read data registered; no dependencies
module fpba_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/fpba_select.sv @@
// fpba_select: single comparator that checks one block capacity per cycle
// and keeps the best candidate so far; uses fpba_pkg
module fpba_select #(
	parameter int unsigned IDX_W     = 3,
	parameter int unsigned SIZE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fpba_pkg::sel_ctl_t    ctl,
	input  logic [IDX_W-1:0]      idx,
	input  logic [SIZE_BITS-1:0]  cap,
	input  logic [SIZE_BITS-1:0]  size,
	output logic                  found,
	output logic [IDX_W-1:0]      pick,
	output logic [SIZE_BITS-1:0]  left
);
	import fpba_pkg::*;

	logic                 fits;
	logic [SIZE_BITS-1:0] cand_left;
	logic                 take;

	assign fits      = cap >= size;
	assign cand_left = cap - size;

	// first and next fit keep the first hit; best and worst keep improving
	always_comb begin
		take = 1'b0;
		if (ctl.vld && fits) begin
			if (!found) begin
				take = 1'b1;
			end else if (ctl.policy == POL_BEST && cand_left < left) begin
				take = 1'b1;
			end else if (ctl.policy == POL_WORST && cand_left > left) begin
				take = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
		end else if (ctl.clear) begin
			found <= 1'b0;
		end else if (take) begin
			found <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pick <= idx;
			left <= cand_left;
		end
	end

endmodule

@@ rtl/fit_policy_block_allocator.sv @@
// fit_policy_block_allocator: top level, request sequencer, capacity ram
// and result register; uses fpba_pkg, fpba_ram and fpba_select
//
//   channel   signals                          direction
//   in        in_valid, in_ready, in_data      request in (load or allocate)
//   out       out_valid, out_ready, out_data   one result per allocate
//   cfg       cfg_we, cfg_index, cfg_data      register write, no wait
//
// a load gives no result; it writes the capacity ram as it is taken
// an allocate reads the searched blocks into the comparator one after another; best or worst
// fit reads every one of them, first or next fit stops once a block fits; the result is then
// registered, and the next request is taken only after the result register has been loaded
// one ram read a cycle feeds the single comparator, then the chosen block is written back
// reset clears all capacities to zero through per-block valid bits, no sweep
// a waiting result stalls the done state: write-back, next result and next request wait
module fit_policy_block_allocator #(
	parameter int unsigned NUM_BLOCKS = 8,
	parameter int unsigned SIZE_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  fpba_pkg::req_t                      in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output fpba_pkg::res_t                      out_data,
	input  logic                                cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fpba_pkg::*;

	localparam int unsigned IDX_W = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;

	state_t               state_q, state_d;
	policy_t              policy_q;
	logic [3:0]           biu_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [3:0]           n_q;
	logic [3:0]           issued_q;
	logic [3:0]           addr_q;
	logic [2:0]           ptr_q;
	logic [NUM_BLOCKS-1:0] vbit_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 out_valid_q;
	res_t                 out_data_q;

	logic                 accept, alloc_acc, load_ok;
	logic [3:0]           n_lim, start;
	logic                 early, issue, scan_done, out_free, done_fire;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [SIZE_BITS-1:0] ram_wdata, ram_rdata, cap_s1;
	sel_ctl_t             sel_ctl;
	logic                 sel_found;
	logic [IDX_W-1:0]     sel_pick;
	logic [SIZE_BITS-1:0] sel_left;

	assign accept    = in_valid && in_ready;
	assign alloc_acc = accept && in_data.opcode == OP_ALLOC;
	assign load_ok   = accept && in_data.opcode == OP_LOAD
		&& 32'(in_data.block_index) < NUM_BLOCKS;

	assign n_lim = (32'(biu_q) > NUM_BLOCKS) ? 4'(NUM_BLOCKS) : biu_q;
	// next fit starts at the pointer unless it lies outside the blocks searched
	assign start = (policy_q == POL_NEXT && {1'b0, ptr_q} < n_lim) ? {1'b0, ptr_q} : 4'd0;

	assign early     = policy_q == POL_FIRST || policy_q == POL_NEXT;
	assign scan_done = (issued_q == n_q && !vld_s1) || (early && sel_found);
	assign out_free  = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (alloc_acc) begin
					state_d = (n_lim == 4'd0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		issue     = 1'b0;
		done_fire = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: issue = issued_q != n_q && !(early && sel_found);
			ST_DONE: done_fire = out_free;
			default: in_ready = 1'b0;
		endcase
	end

	always_comb begin
		ram_we    = load_ok || (done_fire && sel_found);
		ram_waddr = load_ok ? IDX_W'(in_data.block_index) : sel_pick;
		ram_wdata = load_ok ? SIZE_BITS'(in_data.size) : sel_left;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			policy_q    <= POL_FIRST;
			biu_q       <= BIU_RESET;
			n_q         <= '0;
			issued_q    <= '0;
			addr_q      <= '0;
			ptr_q       <= '0;
			vbit_q      <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (cfg_we) begin
				case (cfg_index)
					REG_FIT_POLICY:    policy_q <= policy_t'(cfg_data[1:0]);
					REG_BLOCKS_IN_USE: biu_q <= cfg_data;
					default:           biu_q <= biu_q;
				endcase
			end
			if (alloc_acc) begin
				n_q      <= n_lim;
				issued_q <= '0;
				addr_q   <= start;
			end else if (issue) begin
				issued_q <= issued_q + 4'd1;
				// circular walk over the blocks searched
				addr_q   <= (addr_q + 4'd1 == n_q) ? 4'd0 : addr_q + 4'd1;
			end
			if (ram_we) begin
				vbit_q[ram_waddr] <= 1'b1;
			end
			if (done_fire && sel_found && policy_q == POL_NEXT) begin
				ptr_q <= 3'(sel_pick);
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_acc) begin
			size_q <= SIZE_BITS'(in_data.size);
		end
		if (issue) begin
			idx_s1 <= IDX_W'(addr_q);
		end
		if (done_fire) begin
			out_data_q.granted      <= sel_found;
			out_data_q.chosen_block <= sel_found ? 3'(sel_pick) : 3'd0;
			out_data_q.left_over    <= sel_found ? 16'(sel_left) : 16'd0;
		end
	end

	fpba_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (NUM_BLOCKS)
	) u_cap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (IDX_W'(addr_q)),
		.rdata (ram_rdata)
	);

	// a block never loaded reads as zero capacity
	assign cap_s1 = vbit_q[idx_s1] ? ram_rdata : '0;

	assign sel_ctl.clear  = alloc_acc;
	assign sel_ctl.vld    = vld_s1;
	assign sel_ctl.policy = policy_q;

	fpba_select #(
		.IDX_W     (IDX_W),
		.SIZE_BITS (SIZE_BITS)
	) u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sel_ctl),
		.idx    (idx_s1),
		.cap    (cap_s1),
		.size   (size_q),
		.found  (sel_found),
		.pick   (sel_pick),
		.left   (sel_left)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_refusal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.granted
		|-> out_data_q.chosen_block == 3'd0 && out_data_q.left_over == 16'd0)
		else $error("refused request carries non-zero fields");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> issued_q <= n_q && addr_q < n_q)
		else $error("scan ran past the blocks searched");

	a_pick_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && sel_found |-> 32'(sel_pick) < 32'(n_q))
		else $error("chosen block outside the blocks searched");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.opcode == OP_LOAD |=> state_q == ST_IDLE && !done_fire)
		else $error("load request started a search");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(out_data_q))
		else $error("pending result overwritten");

endmodule

@@ tb/fpba_grant_checker.sv @@
// fpba_grant_checker: watches the request, result and register write ports of the
// block allocator, predicts every grant or refusal and compares it field by field
// depends on fpba_pkg
module fpba_grant_checker #(
	parameter int unsigned NUM_BLOCKS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  fpba_pkg::req_t                  in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  fpba_pkg::res_t                  out_data,
	input  logic                            cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              outstanding
);
	import fpba_pkg::*;

	logic [15:0] cap_left [NUM_BLOCKS];
	logic [2:0]  nf_ptr;
	policy_t     fit_mode;
	logic [3:0]  searched;
	res_t        grants_due [$];
	int          mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		$display("%0t allocator: %s got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic predict_allocation(input req_t r);
		int unsigned n;
		int unsigned start;
		int unsigned j;
		logic [15:0] left;
		logic [15:0] best_left;
		logic [2:0]  pick;
		bit          found;
		res_t        due;
		if (r.opcode == OP_LOAD) begin
			// loads past the last block are dropped
			if (32'(r.block_index) < NUM_BLOCKS)
				cap_left[r.block_index] = r.size;
			return;
		end
		n = (searched > NUM_BLOCKS) ? NUM_BLOCKS : searched;
		found = 1'b0;
		pick = '0;
		best_left = '0;
		if (fit_mode == POL_NEXT) begin
			// circular search from the pointer, back to block zero if it lies past the end
			start = (nf_ptr < n) ? nf_ptr : 0;
			for (int i = 0; i < n && !found; i++) begin
				j = start + i;
				if (j >= n)
					j -= n;
				if (cap_left[j] >= r.size) begin
					pick = j[2:0];
					found = 1'b1;
				end
			end
		end else begin
			for (int i = 0; i < n && !(found && fit_mode == POL_FIRST); i++) begin
				if (cap_left[i] >= r.size) begin
					left = cap_left[i] - r.size;
					if (!found) begin
						pick = i[2:0];
						best_left = left;
						found = 1'b1;
					end else if ((fit_mode == POL_BEST && left < best_left) ||
							(fit_mode == POL_WORST && left > best_left)) begin
						pick = i[2:0];
						best_left = left;
					end
				end
			end
		end
		due = '0;
		if (found) begin
			cap_left[pick] = cap_left[pick] - r.size;
			if (fit_mode == POL_NEXT)
				nf_ptr = pick;
			due.granted = 1'b1;
			due.chosen_block = pick;
			due.left_over = cap_left[pick];
		end
		grants_due.push_back(due);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int b = 0; b < NUM_BLOCKS; b++)
				cap_left[b] = '0;
			nf_ptr = '0;
			fit_mode = POL_FIRST;
			searched = BIU_RESET;
			grants_due.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (grants_due.size() == 0) begin
					report_mismatch("result with no request due, block", out_data.chosen_block, 0);
				end else begin
					want = grants_due.pop_front();
					if (out_data.granted !== want.granted)
						report_mismatch("granted", out_data.granted, want.granted);
					if (out_data.chosen_block !== want.chosen_block)
						report_mismatch("chosen_block", out_data.chosen_block, want.chosen_block);
					if (out_data.left_over !== want.left_over)
						report_mismatch("left_over", out_data.left_over, want.left_over);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_FIT_POLICY)
					fit_mode = policy_t'(cfg_data[1:0]);
				else if (cfg_index == REG_BLOCKS_IN_USE)
					searched = cfg_data;
			end
			if (in_valid && in_ready)
				predict_allocation(in_data);
			outstanding <= grants_due.size();
		end
	end

endmodule

@@ tb/tb_fit_policy_block_allocator.sv @@
// tb_fit_policy_block_allocator: clock, reset, request and register stimulus and
// the verdict for the fit-policy block allocator
// depends on fpba_pkg, fit_policy_block_allocator and fpba_grant_checker
module tb_fit_policy_block_allocator;
	import fpba_pkg::*;

	localparam int unsigned RUN_LIMIT = 400000;
	localparam int unsigned SETTLE    = 16;
	localparam int unsigned LONG_HOLD = 80;
	localparam int unsigned PER_PHASE = 85;
	localparam int unsigned PHASES    = 12;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	req_t                  in_data;
	logic                  out_valid;
	logic                  out_ready;
	res_t                  out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    outstanding;

	bit          tx_gaps;
	bit          rx_gaps;
	int unsigned hold_reqs;
	int unsigned hold_done;

	// policy and searched block count per phase, extremes of both included
	policy_t     phase_pol [PHASES] = '{POL_NEXT, POL_NEXT, POL_BEST, POL_WORST, POL_FIRST,
		POL_BEST, POL_WORST, POL_FIRST, POL_NEXT, POL_BEST, POL_WORST, POL_NEXT};
	logic [3:0]  phase_biu [PHASES] = '{4'd8, 4'd3, 4'd8, 4'd15, 4'd1, 4'd0, 4'd5, 4'd8,
		4'd15, 4'd2, 4'd8, 4'd1};

	fit_policy_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fpba_grant_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	function automatic req_t req_of(input op_t op, input logic [2:0] blk, input logic [15:0] sz);
		req_t r;
		r.opcode = op;
		r.block_index = blk;
		r.size = sz;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int unsigned roll;
		r.block_index = 3'($urandom_range(0, 7));
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 9) < 3) begin
			r.opcode = OP_LOAD;
			if (roll < 40)
				r.size = 16'($urandom_range(0, 65535));
			else if (roll < 70)
				r.size = 16'($urandom_range(0, 1023));
			else if (roll < 90)
				r.size = 16'd256 << $urandom_range(0, 2);  // repeated capacities give ties
			else
				r.size = (roll < 95) ? 16'h0000 : 16'hffff;
		end else begin
			r.opcode = OP_ALLOC;
			if (roll < 50)
				r.size = 16'($urandom_range(0, 255));
			else if (roll < 75)
				r.size = 16'($urandom_range(0, 4095));
			else if (roll < 90)
				r.size = 16'($urandom_range(0, 65535));
			else
				r.size = (roll < 95) ? 16'h0000 : 16'hffff;
		end
		return r;
	endfunction

	// called at a rising edge; returns at the edge where the request is taken
	task automatic send_request(input req_t r);
		int unsigned gap;
		gap = tx_gaps ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	// no new requests until every result is back and the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_regs(input policy_t pol, input logic [3:0] biu);
		cfg_we <= 1'b1;
		cfg_index <= REG_FIT_POLICY;
		cfg_data <= {2'b00, pol};
		@(posedge clk);
		cfg_index <= REG_BLOCKS_IN_USE;
		cfg_data <= biu;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic directed_requests();
		// zero size fits an empty block, any other size is refused
		send_request(req_of(OP_ALLOC, 3'd5, 16'd0));
		send_request(req_of(OP_ALLOC, 3'd0, 16'd1));
		send_request(req_of(OP_LOAD, 3'd0, 16'd100));
		send_request(req_of(OP_LOAD, 3'd1, 16'd0));
		send_request(req_of(OP_LOAD, 3'd2, 16'hffff));
		send_request(req_of(OP_LOAD, 3'd3, 16'd50));
		send_request(req_of(OP_LOAD, 3'd4, 16'd100));
		send_request(req_of(OP_LOAD, 3'd5, 16'h8000));
		send_request(req_of(OP_LOAD, 3'd6, 16'd1));
		send_request(req_of(OP_LOAD, 3'd7, 16'hffff));
		send_request(req_of(OP_ALLOC, 3'd7, 16'hffff));
		send_request(req_of(OP_ALLOC, 3'd0, 16'hffff));
		send_request(req_of(OP_ALLOC, 3'd0, 16'hffff));
		send_request(req_of(OP_ALLOC, 3'd0, 16'd100));
		send_request(req_of(OP_ALLOC, 3'd0, 16'h8000));
		send_request(req_of(OP_ALLOC, 3'd0, 16'd1));
		send_request(req_of(OP_ALLOC, 3'd0, 16'd0));
		send_request(req_of(OP_LOAD, 3'd0, 16'h5555));
		send_request(req_of(OP_LOAD, 3'd7, 16'haaaa));
		send_request(req_of(OP_ALLOC, 3'd2, 16'haaaa));
		send_request(req_of(OP_ALLOC, 3'd5, 16'h5555));
		send_request(req_of(OP_ALLOC, 3'd0, 16'd60));
	endtask

	// result side: random stall per result, plus a long hold when asked for
	initial begin
		int unsigned gap;
		out_ready <= 1'b0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			if (hold_reqs != hold_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done++;
			end
			gap = rx_gaps ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		hold_reqs <= 0;
		rx_gaps <= 1'b0;
		tx_gaps = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_requests();
		for (int p = 0; p < PHASES; p++) begin
			settle();
			program_regs(phase_pol[p], phase_biu[p]);
			tx_gaps = (p != 7) && ($urandom_range(0, 3) != 0);
			rx_gaps <= (p != 7) && ($urandom_range(0, 3) != 0);
			// sender runs flat out while results are held back, so the block fills
			if (p == 2 || p == 8) begin
				tx_gaps = 1'b0;
				hold_reqs <= hold_reqs + 1;
			end
			repeat (PER_PHASE) send_request(random_request());
		end
		settle();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/fpba_pkg.sv
rtl/fpba_ram.sv
rtl/fpba_select.sv
rtl/fit_policy_block_allocator.sv
tb/fpba_grant_checker.sv
tb/tb_fit_policy_block_allocator.sv
